// ===== rtl/core/tlg_pkg.sv =====
// Shared types and constants of the tremolo gain block.
// No dependencies; imported by every module of the block.
package tlg_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned GAIN_BITS   = 9;
  localparam int unsigned UNITY_SHIFT = 8;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 16;

  localparam logic [8:0]  GAIN_RESET       = 9'd64;
  localparam logic [1:0]  WAVE_RESET       = 2'd2;
  localparam logic [7:0]  GAIN_FLOOR_RESET = 8'd64;
  localparam logic [8:0]  GAIN_CEIL_RESET  = 9'd256;
  localparam logic [15:0] CYCLE_LEN_RESET  = 16'd4800;
  localparam logic [7:0]  STEP_RESET       = 8'd1;

  typedef enum logic [1:0] {
    WaveSquare = 2'd0,
    WaveSaw    = 2'd1,
    WaveTri    = 2'd2
  } wave_e;

  typedef enum logic [2:0] {
    RegWaveShape   = 3'd0,
    RegMinGain     = 3'd1,
    RegMaxGain     = 3'd2,
    RegCycleLength = 3'd3,
    RegSawStep     = 3'd4,
    RegTriStep     = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  wave_shape;
    logic [7:0]  gain_floor;
    logic [8:0]  gain_ceil;
    logic [15:0] cycle_length;
    logic [7:0]  saw_step;
    logic [7:0]  tri_step;
  } tlg_cfg_t;

endpackage

// ===== rtl/core/tremolo_lfo_gain.sv =====
// Tremolo: amplitude modulation of a sample stream by a square, sawtooth or triangle LFO.
// Path: queue entry, then output register; throughput one sample per cycle unless the
// output stream stalls, set by the gain update in the front end and one multiplier in the back end.
// Reset (async, active low): config registers return to their defaults, phase to zero,
// gain to 64, triangle direction to up, queue and output register empty.
// Depends on tlg_pkg, tlg_front, tlg_queue and tlg_back.
module tremolo_lfo_gain import tlg_pkg::*; #(
  parameter int unsigned SampleBits = SAMPLE_BITS
) (
  input  logic clk_i,
  input  logic rst_ni,

  // input stream; tdata: sample_in (SampleBits, signed), zero padded to bytes
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((SampleBits + 7) / 8) * 8 - 1:0] s_axis_tdata,

  // output stream; tdata: sample_out (SampleBits, signed), zero padded to bytes
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [((SampleBits + 7) / 8) * 8 - 1:0] m_axis_tdata,

  // register write channel
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  localparam int unsigned DataW  = ((SampleBits + 7) / 8) * 8;
  localparam int unsigned EntryW = SampleBits + GAIN_BITS;

  tlg_cfg_t cfg_q;

  logic              accept;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  logic [EntryW-1:0] entry;
  logic [EntryW-1:0] q_data;
  logic [SampleBits-1:0] out_data;

  // Registers are always ready; the user must write them only while the block is idle (not enforced).
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wave_shape   <= WAVE_RESET;
      cfg_q.gain_floor   <= GAIN_FLOOR_RESET;
      cfg_q.gain_ceil    <= GAIN_CEIL_RESET;
      cfg_q.cycle_length <= CYCLE_LEN_RESET;
      cfg_q.saw_step     <= STEP_RESET;
      cfg_q.tri_step     <= STEP_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegWaveShape:   cfg_q.wave_shape   <= cfg_data_i[1:0];
        RegMinGain:     cfg_q.gain_floor   <= cfg_data_i[7:0];
        RegMaxGain:     cfg_q.gain_ceil    <= cfg_data_i[8:0];
        RegCycleLength: cfg_q.cycle_length <= cfg_data_i[15:0];
        RegSawStep:     cfg_q.saw_step     <= cfg_data_i[7:0];
        RegTriStep:     cfg_q.tri_step     <= cfg_data_i[7:0];
        default: begin
          // unmapped index: drop the write
        end
      endcase
    end
  end

  // Accept a sample whenever the queue has room; the back end drains it on its own.
  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  tlg_front #(
    .SampleBits (SampleBits)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (accept),
    .sample_i (s_axis_tdata[SampleBits-1:0]),
    .entry_o  (entry)
  );

  tlg_queue #(
    .Width (EntryW),
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  tlg_back #(
    .SampleBits (SampleBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_data)
  );

  assign m_axis_tdata = DataW'(out_data);

endmodule

// ===== rtl/core/tlg_front.sv =====
// Front end: LFO phase counter and gain update, one step per accepted sample.
// Depends on tlg_pkg; feeds the sample and its gain to the queue.
module tlg_front import tlg_pkg::*; #(
  parameter int unsigned SampleBits = SAMPLE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tlg_cfg_t              cfg_i,
  input  logic                  accept_i,
  input  logic [SampleBits-1:0] sample_i,
  output logic [SampleBits+GAIN_BITS-1:0] entry_o
);

  logic [15:0] phase_q, phase_d;
  logic [8:0]  gain_q, gain_d;
  logic        down_q, down_d;

  logic [16:0] phase_inc;
  logic [15:0] half_len;
  logic [9:0]  saw_sum;
  logic        tri_down;
  logic signed [10:0] tri_sum;
  logic signed [10:0] max_s, min_s;

  always_comb begin
    phase_inc = {1'b0, phase_q} + 17'd1;
    phase_d   = (phase_inc >= {1'b0, cfg_i.cycle_length}) ? 16'd0 : phase_inc[15:0];
    half_len  = cfg_i.cycle_length >> 1;
    max_s     = $signed({2'b00, cfg_i.gain_ceil});
    min_s     = $signed({3'b000, cfg_i.gain_floor});

    // sawtooth: restart at min on phase zero, else climb and clamp at max
    saw_sum = (phase_d == 16'd0) ? {2'b00, cfg_i.gain_floor}
                                 : ({1'b0, gain_q} + {2'b00, cfg_i.saw_step});
    if (saw_sum > {1'b0, cfg_i.gain_ceil}) begin
      saw_sum = {1'b0, cfg_i.gain_ceil};
    end

    // triangle: turn around at the limits, then step and clamp
    if (gain_q >= cfg_i.gain_ceil) begin
      tri_down = 1'b1;
    end else if (gain_q <= {1'b0, cfg_i.gain_floor}) begin
      tri_down = 1'b0;
    end else begin
      tri_down = down_q;
    end
    tri_sum = tri_down ? ($signed({2'b00, gain_q}) - $signed({3'b000, cfg_i.tri_step}))
                       : ($signed({2'b00, gain_q}) + $signed({3'b000, cfg_i.tri_step}));
    if (tri_sum > max_s) begin
      tri_sum = max_s;
    end else if (tri_sum < min_s) begin
      tri_sum = min_s;
    end

    gain_d = gain_q;
    down_d = down_q;
    case (cfg_i.wave_shape)
      WaveSquare: begin
        gain_d = (phase_d < half_len) ? {1'b0, cfg_i.gain_floor} : cfg_i.gain_ceil;
      end
      WaveSaw: begin
        gain_d = saw_sum[8:0];
      end
      WaveTri: begin
        gain_d = tri_sum[8:0];
        down_d = tri_down;
      end
      default: begin
        // unused code: hold gain and direction
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 16'd0;
      gain_q  <= GAIN_RESET;
      down_q  <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      gain_q  <= gain_d;
      down_q  <= down_d;
    end
  end

  assign entry_o = {gain_d, sample_i};

endmodule

// ===== rtl/core/tlg_queue.sv =====
// Small register queue between the gain front end and the multiply back end.
// Depends on tlg_pkg for default sizes.
module tlg_queue import tlg_pkg::*; #(
  parameter int unsigned Width = SAMPLE_BITS + GAIN_BITS,
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q, count_d;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/core/tlg_back.sv =====
// Back end: sample times gain, arithmetic shift, saturation, output register.
// Depends on tlg_pkg; drains the queue into the master stream.
module tlg_back import tlg_pkg::*; #(
  parameter int unsigned SampleBits = SAMPLE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  logic [SampleBits+GAIN_BITS-1:0] q_data_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [SampleBits-1:0] out_data_o
);

  localparam int unsigned ProdW = SampleBits + GAIN_BITS + 1;
  localparam int unsigned ShW   = ProdW - UNITY_SHIFT;

  logic signed [SampleBits-1:0] sample;
  logic signed [GAIN_BITS:0]    gain_s;
  logic signed [ProdW-1:0]      prod;
  logic [ShW-1:0]               shifted;
  logic [SampleBits-1:0]        sat;
  logic                         load;
  logic                         valid_q;
  logic [SampleBits-1:0]        data_q;

  always_comb begin
    sample  = $signed(q_data_i[SampleBits-1:0]);
    gain_s  = $signed({1'b0, q_data_i[SampleBits+GAIN_BITS-1:SampleBits]});
    prod    = ProdW'(sample) * ProdW'(gain_s);
    shifted = prod[ProdW-1:UNITY_SHIFT];
    // fits when every bit above the result's sign bit repeats it
    if (shifted[ShW-1:SampleBits-1] == '0 || shifted[ShW-1:SampleBits-1] == '1) begin
      sat = shifted[SampleBits-1:0];
    end else if (shifted[ShW-1]) begin
      sat = {1'b1, {(SampleBits-1){1'b0}}};
    end else begin
      sat = {1'b0, {(SampleBits-1){1'b1}}};
    end
  end

  assign load    = !valid_q || out_ready_i;
  assign q_pop_o = q_valid_i && load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      data_q <= sat;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== verif/tremolo_lfo_gain_tb.sv =====
// Self-checking testbench for tremolo_lfo_gain: directed waveform and clamp cases, then
// random register settings with random samples and random idling on both streams.
// Depends on tlg_pkg and the tremolo_lfo_gain RTL.
module tremolo_lfo_gain_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tlg_pkg::*;

  localparam int TDATA_BITS   = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int SAMPLE_MAX   = 2 ** (SAMPLE_BITS - 1) - 1;
  localparam int SAMPLE_MIN   = -SAMPLE_MAX - 1;
  localparam int RANDOM_ITEMS = 1825;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_GUARD  = 4;

  // Waveform code with no shape behind it; the gain must hold.
  localparam logic [1:0] WAVE_UNUSED = 2'd3;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [TDATA_BITS-1:0]    s_axis_tdata  = '0;  // [15:0] sample_in
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [TDATA_BITS-1:0]    m_axis_tdata;        // [15:0] sample_out
  logic                     cfg_valid_i   = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i    = '0;

  // Register shadow, as the block should hold it.
  logic [1:0]           cfg_shape      = WAVE_RESET;
  logic [7:0]           cfg_gain_floor = GAIN_FLOOR_RESET;
  logic [GAIN_BITS-1:0] cfg_gain_ceil  = GAIN_CEIL_RESET;
  logic [15:0]          cfg_cycle_len  = CYCLE_LEN_RESET;
  logic [7:0]           cfg_saw_step   = STEP_RESET;
  logic [7:0]           cfg_tri_step   = STEP_RESET;

  // LFO state mirror.
  logic [15:0]          lfo_phase   = '0;
  logic [GAIN_BITS-1:0] lfo_gain    = GAIN_RESET;
  logic                 lfo_falling = 1'b0;

  sample_t gained_samples[$];   // sample_out values still owed by the block
  int      mismatch_count = 0;
  logic    quiet_run      = 1'b0; // no idling on either stream while set

  tremolo_lfo_gain dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Advance the LFO by one sample and return the modulated, saturated sample.
  function automatic sample_t apply_tremolo(input sample_t smp);
    int next_phase;
    int g;
    int scaled;
    next_phase = int'(lfo_phase) + 1;
    lfo_phase  = (next_phase >= int'(cfg_cycle_len)) ? 16'd0 : next_phase[15:0];
    case (cfg_shape)
      WaveSquare: begin
        lfo_gain = (lfo_phase < (cfg_cycle_len >> 1)) ? {1'b0, cfg_gain_floor} : cfg_gain_ceil;
      end
      WaveSaw: begin
        g = (lfo_phase == 16'd0) ? int'(cfg_gain_floor) : int'(lfo_gain) + int'(cfg_saw_step);
        if (g > int'(cfg_gain_ceil)) g = int'(cfg_gain_ceil);
        lfo_gain = g[GAIN_BITS-1:0];
      end
      WaveTri: begin
        // Turn around at the limits before stepping.
        if (lfo_gain >= cfg_gain_ceil) lfo_falling = 1'b1;
        else if (lfo_gain <= {1'b0, cfg_gain_floor}) lfo_falling = 1'b0;
        g = lfo_falling ? int'(lfo_gain) - int'(cfg_tri_step)
                        : int'(lfo_gain) + int'(cfg_tri_step);
        // The max limit is tested first, so it wins when min is above max.
        if (g > int'(cfg_gain_ceil)) g = int'(cfg_gain_ceil);
        else if (g < int'(cfg_gain_floor)) g = int'(cfg_gain_floor);
        lfo_gain = g[GAIN_BITS-1:0];
      end
      default: ;  // unused code: hold gain and direction
    endcase
    // Floor of the product over unity, then saturate to the sample range.
    scaled = (int'(smp) * int'(lfo_gain)) >>> UNITY_SHIFT;
    if (scaled > SAMPLE_MAX) scaled = SAMPLE_MAX;
    else if (scaled < SAMPLE_MIN) scaled = SAMPLE_MIN;
    return scaled[SAMPLE_BITS-1:0];
  endfunction

  // Present one sample, possibly after a random gap, and record its expected output
  // once the transaction completes. Valid stays high for the next sample.
  task automatic send_sample(input sample_t smp);
    if (!quiet_run && $urandom_range(99) < 9) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 30);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= TDATA_BITS'($unsigned(smp));
    do @(posedge clk_i); while (!s_axis_tready);
    gained_samples.push_back(apply_tremolo(smp));
  endtask

  // Drop valid and hold the sender until every owed output has come back.
  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    while (gained_samples.size() != 0) @(posedge clk_i);
    repeat (DRAIN_GUARD) @(posedge clk_i);
  endtask

  // Write all six registers with the block idle, in index order.
  task automatic program_lfo(input logic [1:0] shape, input logic [7:0] gmin,
                             input logic [GAIN_BITS-1:0] gmax, input logic [15:0] period,
                             input logic [7:0] saw, input logic [7:0] tri_step);
    logic [CFG_DATA_BITS-1:0] vals [6];
    cfg_idx_e idx;
    vals = '{CFG_DATA_BITS'(shape), CFG_DATA_BITS'(gmin), CFG_DATA_BITS'(gmax),
             CFG_DATA_BITS'(period), CFG_DATA_BITS'(saw), CFG_DATA_BITS'(tri_step)};
    hold_until_drained();
    for (int i = 0; i < 6; i++) begin
      idx = cfg_idx_e'(i);
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx)
        RegWaveShape:   cfg_shape      = vals[i][1:0];
        RegMinGain:     cfg_gain_floor = vals[i][7:0];
        RegMaxGain:     cfg_gain_ceil  = vals[i][GAIN_BITS-1:0];
        RegCycleLength: cfg_cycle_len  = vals[i][15:0];
        RegSawStep:     cfg_saw_step   = vals[i][7:0];
        RegTriStep:     cfg_tri_step   = vals[i][7:0];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Reset settings: triangle between 64 and 256; full-scale, zero, minus one and alternating-bit samples.
  task automatic test_reset_defaults();
    sample_t picks [6] = '{sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN), '0, -1,
                           16'h5555, 16'haaaa};
    foreach (picks[i]) send_sample(picks[i]);
  endtask

  // Square wave over a four-sample cycle, then cycle lengths zero and one.
  task automatic test_square_wave();
    sample_t picks [4] = '{sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN), 16'sd1000, -16'sd1000};
    program_lfo(WaveSquare, 8'd0, 9'd256, 16'd4, STEP_RESET, STEP_RESET);
    foreach (picks[i]) send_sample(picks[i]);
    // Phase pinned at zero with half zero: max gain every sample.
    program_lfo(WaveSquare, 8'd0, 9'd256, 16'd0, STEP_RESET, STEP_RESET);
    send_sample(sample_t'(SAMPLE_MAX));
    send_sample(sample_t'(SAMPLE_MIN));
    program_lfo(WaveSquare, 8'd255, 9'd1, 16'd1, STEP_RESET, STEP_RESET);
    send_sample(sample_t'(SAMPLE_MIN));
  endtask

  // Sawtooth with the largest step and a gain above unity: clamp at max and saturate.
  task automatic test_sawtooth_clamp();
    program_lfo(WaveSaw, 8'd255, 9'd511, 16'd3, 8'd255, STEP_RESET);
    send_sample(sample_t'(SAMPLE_MAX));
    send_sample(sample_t'(SAMPLE_MIN));
    send_sample(sample_t'(SAMPLE_MAX));
    send_sample(sample_t'(SAMPLE_MIN));
  endtask

  // Triangle with min above max, then a step that would go below zero.
  task automatic test_triangle_clamps();
    program_lfo(WaveTri, 8'd200, 9'd1, 16'd65535, STEP_RESET, 8'd255);
    send_sample(sample_t'(SAMPLE_MAX));
    send_sample(-16'sd12345);
    program_lfo(WaveTri, 8'd0, 9'd511, 16'd65535, STEP_RESET, 8'd255);
    repeat (5) send_sample(sample_t'(SAMPLE_MIN));
  endtask

  // Unused waveform code: gain and direction stay where they were.
  task automatic test_unused_shape();
    program_lfo(WAVE_UNUSED, 8'd10, 9'd300, 16'd2, 8'd7, 8'd9);
    send_sample(sample_t'(SAMPLE_MAX));
    send_sample(16'sh1234);
  endtask

  function automatic sample_t random_sample();
    case ($urandom_range(9))
      0:       return $urandom_range(1) ? sample_t'(SAMPLE_MAX) : sample_t'(SAMPLE_MIN);
      1:       return sample_t'($signed($urandom_range(16)) - 8);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Random settings per phase, biased toward short cycles so the LFO wraps often.
  task automatic test_random_settings();
    int sent;
    int phase_no;
    int run_len;
    logic [1:0]           shape;
    logic [GAIN_BITS-1:0] gmax;
    logic [15:0]          period;
    logic [7:0]           saw;
    logic [7:0]           tri_step;
    sent     = 0;
    phase_no = 0;
    while (sent < RANDOM_ITEMS) begin
      shape = ($urandom_range(9) == 0) ? WAVE_UNUSED : 2'($urandom_range(2));
      case ($urandom_range(7))
        0:       gmax = 9'($urandom_range(257, 511));
        1:       gmax = $urandom_range(1) ? 9'd0 : 9'd511;
        default: gmax = 9'($urandom_range(1, 256));
      endcase
      case ($urandom_range(9))
        0:       period = 16'($urandom_range(1));
        1:       period = 16'd65535;
        2:       period = 16'($urandom_range(41, 65535));
        default: period = 16'($urandom_range(2, 40));
      endcase
      saw      = $urandom_range(1) ? 8'($urandom_range(8)) : 8'($urandom);
      tri_step = $urandom_range(1) ? 8'($urandom_range(8)) : 8'($urandom);
      program_lfo(shape, 8'($urandom), gmax, period, saw, tri_step);
      // One phase runs with both streams flat out.
      quiet_run = (phase_no == 3);
      run_len   = $urandom_range(80, 200);
      if (run_len > RANDOM_ITEMS - sent) run_len = RANDOM_ITEMS - sent;
      repeat (run_len) send_sample(random_sample());
      sent     += run_len;
      phase_no += 1;
    end
    quiet_run = 1'b0;
  endtask

  // Randomly stall the output side.
  always @(posedge clk_i) begin
    m_axis_tready <= quiet_run || ($urandom_range(99) >= 9);
  end

  // Check each output transaction against the oldest owed sample.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (gained_samples.size() == 0) begin
        $error("sample_out: expected none, got %0d", $signed(m_axis_tdata[SAMPLE_BITS-1:0]));
        mismatch_count++;
      end else if (m_axis_tdata[SAMPLE_BITS-1:0] !== gained_samples[0]) begin
        $error("sample_out: expected %0d, got %0d", gained_samples[0],
               $signed(m_axis_tdata[SAMPLE_BITS-1:0]));
        mismatch_count++;
        void'(gained_samples.pop_front());
      end else begin
        void'(gained_samples.pop_front());
      end
    end
  end

  // End the run when no transaction of any kind has completed for too long.
  initial begin : watchdog
    int stalled_edges;
    stalled_edges = 0;
    wait (rst_ni);
    while (stalled_edges < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stalled_edges = 0;
      end else begin
        stalled_edges++;
      end
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_square_wave();
    test_sawtooth_clamp();
    test_triangle_clamps();
    test_unused_shape();
    test_random_settings();
    hold_until_drained();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
